>>> hw/rtl/sbsl_pkg.sv
// ----------------------------------------------------------------------------
// sbsl_pkg
// Shared types, field widths and codes of the sorted breakpoint locator.
// ----------------------------------------------------------------------------
package sbsl_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam int POS_W    = 32;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int ENTRY_W  = OWNER_W + POS_W;

    // Position 1.0 in Q16.16 and weight 1.0 in Q1.16.
    localparam logic [POS_W-1:0]    POS_ONE    = 32'h0001_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

    // Action codes of an input beat.
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] ST_QUERY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [OWNER_W-1:0]      owner;
        logic signed [POS_W-1:0] pos;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> hw/rtl/sbsl_ram.sv
// ----------------------------------------------------------------------------
// sbsl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sbsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/sbsl_div.sv
// ----------------------------------------------------------------------------
// sbsl_div
// Restoring divider giving the fractional quotient num/den, one bit a cycle.
// ----------------------------------------------------------------------------
module sbsl_div
    import sbsl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(FRAC_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]  den_reg, den_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [POS_W:0]    trial;

    // The caller guarantees 0 < num < den, so the remainder always fits.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, 1'b0};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = POS_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[POS_W-1:0];
                quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> hw/rtl/sorted_breakpoint_segment_locator.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_segment_locator
// Sorted table of (owner, position) breakpoints with segment lookup.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries action, input_index
// and position; one output channel (out_valid/out_ready) carries status,
// lower_index, upper_index and weight. Every input beat gives exactly one
// result beat, in order. One item is worked on at a time.
// A set beat scans the owners one entry a cycle, then moves the changed
// entry one place a cycle through the table until it sits in order; a
// refused set skips the moves and goes straight to its result.
// A query beat walks the positions one entry a cycle; unless the position
// lies past the last entry it then works out the segment width and the
// clamp tests in S_PREP and S_CHK, and runs the serial divider unless the
// weight clamps. The table RAM read port sets the walk speed and the
// one-bit-a-cycle divider sets the tail. The next beat can be taken in the
// cycle in which the result appears.
// After reset the block writes the default breakpoints (owner 0 at 0.0,
// owner 1 at 1.0) into the RAM in S_INIT0 and S_INIT1; in_ready stays low then.
// The result is held in an output register: while the receiver stalls the
// next item is still taken and worked on, and only waits at its end for the
// output register to free up.
// ----------------------------------------------------------------------------
module sorted_breakpoint_segment_locator
    import sbsl_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [OWNER_W-1:0]         input_index,
    input  logic signed [POS_W-1:0]    position,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [OWNER_W-1:0]         lower_index,
    output logic [OWNER_W-1:0]         upper_index,
    output logic [WEIGHT_W-1:0]        weight
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [3:0] S_INIT0 = 4'd0;
    localparam logic [3:0] S_INIT1 = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_LGO   = 4'd4;
    localparam logic [3:0] S_LEFT  = 4'd5;
    localparam logic [3:0] S_RGO   = 4'd6;
    localparam logic [3:0] S_RIGHT = 4'd7;
    localparam logic [3:0] S_PUT   = 4'd8;
    localparam logic [3:0] S_WLO   = 4'd9;
    localparam logic [3:0] S_WALK  = 4'd10;
    localparam logic [3:0] S_PREP  = 4'd11;
    localparam logic [3:0] S_CHK   = 4'd12;
    localparam logic [3:0] S_DIV   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             moved_reg, moved_next;

    // Item payload and working values.
    logic [IDX_W-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [OWNER_W-1:0]      idx_reg, idx_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    entry_t                  lo_reg, lo_next;
    logic signed [POS_W-1:0] hi_pos_reg, hi_pos_next;
    logic signed [POS_W:0]   d_reg, d_next;
    logic signed [POS_W:0]   num_reg, num_next;

    // Finished result, then the output register.
    logic [STATUS_W-1:0] status_res_reg, status_res_next;
    logic [OWNER_W-1:0]  lower_res_reg, lower_res_next;
    logic [OWNER_W-1:0]  upper_res_reg, upper_res_next;
    logic [WEIGHT_W-1:0] weight_res_reg, weight_res_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OWNER_W-1:0]  lower_reg, lower_next;
    logic [OWNER_W-1:0]  upper_reg, upper_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;

    // Table RAM ports.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_e;
    entry_t             wr_e;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CNT_W:0]   j_p1;
    logic [CNT_W:0]   j_p2;
    logic [CNT_W:0]   cnt_ext;
    logic             k_last;

    sbsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rd_e      = entry_t'(ram_rdata);
    assign ram_wdata = ENTRY_W'(wr_e);
    assign j_p1      = (CNT_W + 1)'(j_reg) + (CNT_W + 1)'(1);
    assign j_p2      = (CNT_W + 1)'(j_reg) + (CNT_W + 1)'(2);
    assign cnt_ext   = (CNT_W + 1)'(count_reg);
    assign k_last    = (CNT_W'(k_reg) == count_reg - CNT_W'(1));
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        moved_next      = moved_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_pos_next     = hi_pos_reg;
        d_next          = d_reg;
        num_next        = num_reg;
        status_res_next = status_res_reg;
        lower_res_next  = lower_res_reg;
        upper_res_next  = upper_res_reg;
        weight_res_next = weight_res_reg;
        status_next     = status_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        weight_next     = weight_reg;
        ram_we          = 1'b0;
        ram_waddr       = j_reg;
        ram_raddr       = k_reg;
        wr_e            = rd_e;
        div_req.start   = 1'b0;
        div_req.num     = num_reg[POS_W-1:0];
        div_req.den     = d_reg[POS_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                wr_e.owner = '0;
                wr_e.pos   = '0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(1);
                wr_e.owner = OWNER_W'(1);
                wr_e.pos   = POS_ONE;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next        = input_index;
                    pos_next        = position;
                    k_next          = '0;
                    ram_raddr       = '0;
                    moved_next      = 1'b0;
                    status_res_next = ST_QUERY;
                    lower_res_next  = '0;
                    upper_res_next  = '0;
                    weight_res_next = '0;
                    state_next      = (action == ACT_SET) ? S_SRCH : S_WLO;
                end
            end
            S_SRCH:
            begin
                // Look for the owner; the data of entry k arrives this cycle.
                if (rd_e.owner == idx_reg)
                begin
                    j_next          = k_reg;
                    status_res_next = ST_UPDATED;
                    state_next      = S_LGO;
                end
                else if (k_last)
                begin
                    if (count_reg >= CNT_W'(MAX_ENTRIES))
                    begin
                        status_res_next = ST_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        j_next          = IDX_W'(count_reg);
                        count_next      = count_reg + CNT_W'(1);
                        status_res_next = ST_INSERTED;
                        state_next      = S_LGO;
                    end
                end
                else
                begin
                    k_next    = k_reg + IDX_W'(1);
                    ram_raddr = k_reg + IDX_W'(1);
                end
            end
            S_LGO:
            begin
                if (j_reg == '0)
                begin
                    state_next = S_RGO;
                end
                else
                begin
                    ram_raddr  = j_reg - IDX_W'(1);
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                // Shift strictly greater neighbours up by one place.
                if (rd_e.pos > pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = j_reg;
                    j_next     = j_reg - IDX_W'(1);
                    moved_next = 1'b1;
                    if (j_reg == IDX_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_raddr = j_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    state_next = moved_reg ? S_PUT : S_RGO;
                end
            end
            S_RGO:
            begin
                if (j_p1 < cnt_ext)
                begin
                    ram_raddr  = j_reg + IDX_W'(1);
                    state_next = S_RIGHT;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_RIGHT:
            begin
                // Equal later neighbours stay after the moved entry.
                if (rd_e.pos < pos_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    j_next    = j_reg + IDX_W'(1);
                    if (j_p2 < cnt_ext)
                    begin
                        ram_raddr = j_reg + IDX_W'(2);
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                wr_e.owner = idx_reg;
                wr_e.pos   = pos_reg;
                state_next = S_FIN;
            end
            S_WLO:
            begin
                lo_next    = rd_e;
                k_next     = IDX_W'(1);
                ram_raddr  = IDX_W'(1);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (pos_reg > rd_e.pos)
                begin
                    if (k_last)
                    begin
                        lower_res_next = rd_e.owner;
                        upper_res_next = rd_e.owner;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        lo_next   = rd_e;
                        k_next    = k_reg + IDX_W'(1);
                        ram_raddr = k_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    hi_pos_next    = rd_e.pos;
                    lower_res_next = lo_reg.owner;
                    upper_res_next = rd_e.owner;
                    state_next     = S_PREP;
                end
            end
            S_PREP:
            begin
                d_next     = {hi_pos_reg[POS_W-1], hi_pos_reg}
                           - {lo_reg.pos[POS_W-1], lo_reg.pos};
                num_next   = {pos_reg[POS_W-1], pos_reg}
                           - {lo_reg.pos[POS_W-1], lo_reg.pos};
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Zero-width segments and positions below the start give 0.
                if (d_reg <= 0 || num_reg <= 0)
                begin
                    weight_res_next = '0;
                    state_next      = S_FIN;
                end
                else if (num_reg >= d_reg)
                begin
                    weight_res_next = WEIGHT_ONE;
                    state_next      = S_FIN;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    weight_res_next = {1'b0, div_rsp.quot};
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = status_res_reg;
                    lower_next     = lower_res_reg;
                    upper_next     = upper_res_reg;
                    weight_next    = weight_res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            count_reg     <= CNT_W'(2);
            out_valid_reg <= 1'b0;
            moved_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            moved_reg     <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_pos_reg     <= hi_pos_next;
        d_reg          <= d_next;
        num_reg        <= num_next;
        status_res_reg <= status_res_next;
        lower_res_reg  <= lower_res_next;
        upper_res_reg  <= upper_res_next;
        weight_res_reg <= weight_res_next;
        status_reg     <= status_next;
        lower_reg      <= lower_next;
        upper_reg      <= upper_next;
        weight_reg     <= weight_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign lower_index = lower_reg;
    assign upper_index = upper_reg;
    assign weight      = weight_reg;

endmodule

>>> test/sorted_breakpoint_segment_locator_test.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_segment_locator_test
// Self-checking bench for the sorted breakpoint table and segment lookup.
// A short table of directed beats covers the reset table, extreme positions,
// updates, inserts, equal positions, a zero-width first segment and a refused
// insert into a full table. About 1450 random beats follow under three idling
// patterns and one long output hold. Every result beat is checked against a
// behavioural model of the table that is kept in step with the block.
// ----------------------------------------------------------------------------
module sorted_breakpoint_segment_locator_test;
    import sbsl_pkg::*;

    localparam int TABLE_DEPTH   = DEFAULT_MAX_ENTRIES;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int N_DIRECTED    = 25;

    // One result beat, laid out in the order of the output ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OWNER_W-1:0]  lower;
        logic [OWNER_W-1:0]  upper;
        logic [WEIGHT_W-1:0] weight;
    } locator_result_t;

    // One directed beat. Where known is set, want is the result read straight
    // off the behaviour; otherwise the table model supplies the expectation.
    typedef struct packed {
        logic               act;
        logic [OWNER_W-1:0] idx;
        logic [POS_W-1:0]   pos;
        logic               known;
        locator_result_t    want;
    } stimulus_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    action;
    logic [OWNER_W-1:0]      input_index;
    logic signed [POS_W-1:0] position;
    logic                    out_valid;
    logic                    out_ready;
    logic [STATUS_W-1:0]     status;
    logic [OWNER_W-1:0]      lower_index;
    logic [OWNER_W-1:0]      upper_index;
    logic [WEIGHT_W-1:0]     weight;

    // Model of the breakpoint table: positions and owners kept sorted.
    logic signed [POS_W-1:0] bp_pos [TABLE_DEPTH];
    logic [OWNER_W-1:0]      bp_owner [TABLE_DEPTH];
    int                      bp_count;

    locator_result_t pending_results [$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    int  load_phase;
    logic rx_hold = 1'b0;
    int  cycle_count = 0;
    int  beats_in = 0;
    int  results_checked = 0;
    int  failure_count = 0;
    int  held_stalls = 0;
    int  status_seen [4] = '{0, 0, 0, 0};

    // The directed beats. After reset the table holds owner 0 at 0.0 and
    // owner 1 at 1.0, so the first queries can be typed in by hand. The run
    // then moves owner 0 to 2.0, adds owners at the lowest position and at
    // 2.0 (equal positions must keep their insertion order), and fills the
    // table with eleven more owners so that the next new owner is refused.
    stimulus_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_QUERY, 8'h00, 32'h0000_0000, 1'b1, '{ST_QUERY, 8'd0, 8'd1, 17'd0}},
        '{ACT_QUERY, 8'h00, 32'h0000_8000, 1'b1, '{ST_QUERY, 8'd0, 8'd1, 17'h0_8000}},
        '{ACT_QUERY, 8'h00, POS_ONE,       1'b1, '{ST_QUERY, 8'd0, 8'd1, WEIGHT_ONE}},
        '{ACT_QUERY, 8'hFF, 32'h7FFF_FFFF, 1'b1, '{ST_QUERY, 8'd1, 8'd1, 17'd0}},
        '{ACT_QUERY, 8'h5A, 32'h8000_0000, 1'b1, '{ST_QUERY, 8'd0, 8'd1, 17'd0}},
        '{ACT_SET,   8'h00, 32'h0002_0000, 1'b1, '{ST_UPDATED, 8'd0, 8'd0, 17'd0}},
        '{ACT_QUERY, 8'h00, 32'h0001_8000, 1'b0, '0},
        '{ACT_SET,   8'hFF, 32'h8000_0000, 1'b1, '{ST_INSERTED, 8'd0, 8'd0, 17'd0}},
        '{ACT_SET,   8'h07, 32'h0002_0000, 1'b0, '0},
        '{ACT_SET,   8'h09, 32'h8000_0000, 1'b0, '0},
        '{ACT_QUERY, 8'h00, 32'h8000_0000, 1'b0, '0},
        '{ACT_QUERY, 8'h00, 32'h0000_0000, 1'b0, '0},
        '{ACT_SET,   8'h80, 32'h7FFF_FFFF, 1'b0, '0},
        '{ACT_SET,   8'h40, 32'hFFFF_0000, 1'b0, '0},
        '{ACT_SET,   8'h20, 32'h0001_0000, 1'b0, '0},
        '{ACT_SET,   8'h10, 32'h0000_0001, 1'b0, '0},
        '{ACT_SET,   8'h08, 32'h0001_8000, 1'b0, '0},
        '{ACT_SET,   8'h02, 32'h7FFF_FFFF, 1'b0, '0},
        '{ACT_SET,   8'h04, 32'hC000_0000, 1'b0, '0},
        '{ACT_SET,   8'hAA, 32'h1234_5678, 1'b0, '0},
        '{ACT_SET,   8'h55, 32'h0001_0000, 1'b0, '0},
        '{ACT_SET,   8'hFE, 32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_SET,   8'h03, 32'h0000_4000, 1'b0, '0},
        '{ACT_SET,   8'h11, 32'h0000_0000, 1'b1, '{ST_FULL, 8'd0, 8'd0, 17'd0}},
        '{ACT_QUERY, 8'h00, 32'h7FFF_FFFF, 1'b0, '0}
    };

    sorted_breakpoint_segment_locator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .input_index (input_index),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .lower_index (lower_index),
        .upper_index (upper_index),
        .weight      (weight)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Applies one accepted beat to the table model and returns the result
    // that the block must give for it.
    function automatic locator_result_t step_breakpoint_table(
        input logic act,
        input logic [OWNER_W-1:0] idx,
        input logic signed [POS_W-1:0] pos
    );
        locator_result_t         r;
        int                      i;
        int                      j;
        int                      slot;
        int                      cur;
        logic signed [POS_W-1:0] p;
        logic [OWNER_W-1:0]      o;
        logic signed [63:0]      lo;
        logic signed [63:0]      hi;
        logic signed [63:0]      span;
        logic signed [63:0]      offset;
        logic [63:0]             frac;

        r = '0;
        if (act == ACT_SET)
        begin
            slot = -1;
            for (i = 0; i < bp_count; i++)
            begin
                if (slot < 0 && bp_owner[i] == idx)
                    slot = i;
            end
            if (slot >= 0)
            begin
                bp_pos[slot] = pos;
                r.status = ST_UPDATED;
            end
            else if (bp_count >= TABLE_DEPTH)
            begin
                // A refused insert leaves the table exactly as it was.
                r.status = ST_FULL;
                return r;
            end
            else
            begin
                bp_pos[bp_count] = pos;
                bp_owner[bp_count] = idx;
                bp_count++;
                r.status = ST_INSERTED;
            end
            // Stable insertion sort: only strictly greater entries move up,
            // so equal positions keep the order in which they were stored.
            for (i = 1; i < bp_count; i++)
            begin
                p = bp_pos[i];
                o = bp_owner[i];
                j = i;
                while (j > 0 && bp_pos[j-1] > p)
                begin
                    bp_pos[j] = bp_pos[j-1];
                    bp_owner[j] = bp_owner[j-1];
                    j--;
                end
                bp_pos[j] = p;
                bp_owner[j] = o;
            end
            return r;
        end

        cur = 0;
        while (cur < bp_count - 1 && pos > bp_pos[cur+1])
            cur++;
        r.status = ST_QUERY;
        if (cur == bp_count - 1)
        begin
            r.lower = bp_owner[cur];
            r.upper = bp_owner[cur];
        end
        else
        begin
            lo = 64'(bp_pos[cur]);
            hi = 64'(bp_pos[cur+1]);
            span = hi - lo;
            offset = 64'(pos) - lo;
            if (span <= 0 || offset <= 0)
                frac = 64'd0;
            else if (offset >= span)
                frac = 64'd65536;
            else
                frac = (64'(offset) << FRAC_W) / 64'(span);
            r.lower = bp_owner[cur];
            r.upper = bp_owner[cur+1];
            r.weight = frac[WEIGHT_W-1:0];
        end
        return r;
    endfunction

    // Random positions lean on the breakpoints already in the table, so that
    // exact hits, near misses and equal positions turn up often.
    function automatic logic [POS_W-1:0] pick_position();
        int               sel;
        logic [31:0]      r;
        logic [POS_W-1:0] near;

        sel = $urandom_range(99);
        r = $urandom;
        near = bp_pos[$urandom_range(bp_count - 1)];
        if (sel < 25)
            return near;
        else if (sel < 40)
            return near + $urandom_range(8) - 32'd4;
        else if (sel < 70)
            return {{13{r[18]}}, r[18:0]};
        else if (sel < 80)
        begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return POS_ONE;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return r;
    endfunction

    function automatic string describe_result(input locator_result_t r);
        return $sformatf("status %0d lower %0d upper %0d weight %0d",
            r.status, r.lower, r.upper, r.weight);
    endfunction

    task automatic report_failure(input string msg);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("MISMATCH: %s", msg);
    endtask

    // Offers one beat and waits for it to be taken. The expectation is
    // formed at the edge of acceptance, which keeps the model in the order
    // in which the block sees the beats.
    task automatic offer_beat(
        input logic act,
        input logic [OWNER_W-1:0] idx,
        input logic [POS_W-1:0] pos,
        input logic known,
        input locator_result_t want
    );
        locator_result_t predicted;

        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        input_index <= idx;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_breakpoint_table(act, idx, pos);
        if (known)
            predicted = want;
        pending_results = {pending_results, predicted};
        beats_in++;
    endtask

    // Checks one accepted result beat against the oldest expectation.
    task automatic check_result();
        locator_result_t want;
        locator_result_t got;

        got.status = status;
        got.lower = lower_index;
        got.upper = upper_index;
        got.weight = weight;
        if (pending_results.size() == 0)
        begin
            report_failure($sformatf("result beat with nothing expected: %s",
                describe_result(got)));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (got !== want)
            report_failure($sformatf("result %0d: expected %s, got %s",
                results_checked, describe_result(want), describe_result(got)));
    endtask

    // Receiver. Signals are sampled at the edge, before the block's own
    // updates of that edge land, and out_ready is driven for the next edge.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (rx_hold && in_valid && !in_ready)
                held_stalls++;
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Once the last phase starts the receiver is held off for a long stretch
    // while the sender keeps offering beats, so the block must fill its
    // output register and then hold in_ready low.
    initial
    begin
        wait (load_phase == 2);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog on the cycle counter.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d beats in, %0d results checked",
            cycle_count, beats_in, results_checked);
        $display("sorted_breakpoint_segment_locator_test NOT OK");
        $finish;
    end

    initial
    begin
        int                 i;
        int                 waited;
        logic               act;
        logic [OWNER_W-1:0] idx;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_SET;
        input_index <= '0;
        position <= '0;

        // The model starts from the reset table: owner 0 at 0.0, owner 1 at 1.0.
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            bp_pos[i] = '0;
            bp_owner[i] = '0;
        end
        bp_pos[1] = POS_ONE;
        bp_owner[1] = 8'd1;
        bp_count = 2;

        tx_idle_pct = 35;
        rx_idle_pct = 68;
        load_phase = 0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            offer_beat(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].pos,
                directed_rows[i].known, directed_rows[i].want);

        // Random beats in three phases: the sender idles less than the
        // receiver, then the other way round, then neither idles.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 35;
                load_phase = 1;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                load_phase = 2;
            end
            act = ($urandom_range(99) < 45) ? ACT_QUERY : ACT_SET;
            // Most sets name an owner already in the table, so that updates
            // keep reshuffling it; the rest try a fresh owner.
            if (act == ACT_SET && $urandom_range(99) < 80)
                idx = bp_owner[$urandom_range(bp_count - 1)];
            else
                idx = OWNER_W'($urandom_range(255));
            offer_beat(act, idx, pick_position(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // Then wait out SETTLE_CYCLES to catch any stray result beat.
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
            report_failure($sformatf("%0d expected results never arrived",
                pending_results.size()));

        $display("covered %0d beats: %0d queries, %0d inserts, %0d updates, %0d refused",
            beats_in, status_seen[ST_QUERY], status_seen[ST_INSERTED],
            status_seen[ST_UPDATED], status_seen[ST_FULL]);
        $display("%0d results checked, input held back %0d cycles in the hold, %0d failures",
            results_checked, held_stalls, failure_count);
        if (failure_count == 0)
            $display("sorted_breakpoint_segment_locator_test OK");
        else
            $display("sorted_breakpoint_segment_locator_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sbsl_pkg.sv
hw/rtl/sbsl_ram.sv
hw/rtl/sbsl_div.sv
hw/rtl/sorted_breakpoint_segment_locator.sv
test/sorted_breakpoint_segment_locator_test.sv
